// ===== rtl/core/wst_pkg.sv =====
// shared types and character constants for the word and sentence tokenizer
`timescale 1ns / 1ps
`default_nettype none
package wst_pkg;

  // width of the minimum word length register
  localparam int CFG_W = 6;

  // depth of the command queue between front and back
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = 2;

  // characters with a special meaning
  localparam logic [7:0] CH_LOW_A  = 8'h61;
  localparam logic [7:0] CH_LOW_E  = 8'h65;
  localparam logic [7:0] CH_LOW_H  = 8'h68;
  localparam logic [7:0] CH_LOW_T  = 8'h74;
  localparam logic [7:0] CH_LOW_Z  = 8'h7a;
  localparam logic [7:0] CH_UP_A   = 8'h41;
  localparam logic [7:0] CH_UP_Z   = 8'h5a;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_DASH   = 8'h2d;
  localparam logic [7:0] CH_AMP    = 8'h26;
  localparam logic [7:0] CH_PERIOD = 8'h2e;
  localparam logic [7:0] CH_QUEST  = 8'h3f;
  localparam logic [7:0] CH_EXCL   = 8'h21;
  localparam logic [7:0] CASE_BIT  = 8'h20;

  // input operation codes
  localparam logic OP_TEXT = 1'b0;
  localparam logic OP_EOI  = 1'b1;

  // result kind codes
  localparam logic KIND_CHAR   = 1'b0;
  localparam logic KIND_MARKER = 1'b1;

  // classified command handed from front to back
  typedef enum logic [1:0] {
    CMD_CHAR = 2'd0,
    CMD_SEP  = 2'd1,
    CMD_EOI  = 2'd2
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t    op;
    logic [7:0] ch;         // lowercased word character
    logic       is_letter;  // character is a letter
    logic       sent_end;   // separator also closes the sentence
  } tok_cmd_t;

endpackage
`default_nettype wire

// ===== rtl/core/wst_front.sv =====
// front end: classifies input bytes into commands and queues them for the back end
`timescale 1ns / 1ps
`default_nettype none
module wst_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic              in_operation,
  input  wire logic [7:0]        in_text_byte,
  output logic                   cmd_valid,
  output wst_pkg::tok_cmd_t      cmd,
  input  wire logic              cmd_pop
);

  localparam int QD = wst_pkg::Q_DEPTH;
  localparam int QA = wst_pkg::Q_AW;

  wst_pkg::tok_cmd_t queue_r [QD];
  logic [QA-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [QA-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [QA:0]       count_r, count_nxt;
  logic              push;
  wst_pkg::tok_cmd_t cls;
  logic              is_upper, is_lower, is_digit, is_word;

  // character classes
  always_comb begin
    is_upper = (in_text_byte >= wst_pkg::CH_UP_A) && (in_text_byte <= wst_pkg::CH_UP_Z);
    is_lower = (in_text_byte >= wst_pkg::CH_LOW_A) && (in_text_byte <= wst_pkg::CH_LOW_Z);
    is_digit = (in_text_byte >= wst_pkg::CH_ZERO) && (in_text_byte <= wst_pkg::CH_NINE);
    is_word  = is_upper || is_lower || is_digit ||
               (in_text_byte == wst_pkg::CH_DASH) || (in_text_byte == wst_pkg::CH_AMP);
  end

  // command built from one input transfer
  always_comb begin
    cls.ch        = is_upper ? (in_text_byte | wst_pkg::CASE_BIT) : in_text_byte;
    cls.is_letter = is_upper || is_lower;
    cls.sent_end  = (in_text_byte == wst_pkg::CH_PERIOD) ||
                    (in_text_byte == wst_pkg::CH_QUEST) ||
                    (in_text_byte == wst_pkg::CH_EXCL);
    if (in_operation == wst_pkg::OP_EOI) begin
      cls.op = wst_pkg::CMD_EOI;
    end else if (is_word) begin
      cls.op = wst_pkg::CMD_CHAR;
    end else begin
      cls.op = wst_pkg::CMD_SEP;
    end
  end

  // queue control
  assign in_stall  = (count_r == (QA+1)'(QD));
  assign push      = in_valid && !in_stall;
  assign cmd_valid = (count_r != '0);
  assign cmd       = queue_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = cmd_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + (QA+1)'(push) - (QA+1)'(cmd_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      queue_r[wr_ptr_r] <= cls;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/wst_back.sv =====
// back end: word buffer, keep test, character emission and sentence markers
`timescale 1ns / 1ps
`default_nettype none
module wst_back #(
  parameter int MAX_WORD_LEN = 32
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_valid,
  input  wire logic [wst_pkg::CFG_W-1:0]     cfg_data,
  input  wire logic                          cmd_valid,
  input  wire wst_pkg::tok_cmd_t             cmd,
  output logic                               cmd_pop,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic                               out_kind,
  output logic [7:0]                         out_word_char,
  output logic                               out_word_end,
  output logic                               out_truncated,
  output logic                               out_last
);

  localparam int CW   = wst_pkg::CFG_W;
  localparam int LENW = $clog2(MAX_WORD_LEN + 2);
  localparam int IDXW = $clog2(MAX_WORD_LEN);
  localparam logic [LENW-1:0] LEN_MAX = LENW'(MAX_WORD_LEN);
  localparam logic [LENW-1:0] LEN_SAT = LENW'(MAX_WORD_LEN + 1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EMIT = 3'b010,
    S_MARK = 3'b100
  } state_t;

  state_t          state_r, state_nxt;
  logic [CW-1:0]   min_len_r;
  logic [LENW-1:0] len_r, len_nxt;
  logic            inside_r, inside_nxt;
  logic            has_r, has_nxt;
  logic [IDXW-1:0] idx_r, idx_nxt;
  logic [IDXW-1:0] last_idx_r, last_idx_nxt;
  logic            trunc_r, trunc_nxt;
  logic            mark_r, mark_nxt;
  logic            first_letter_r;
  logic [7:0]      c0_r, c1_r, c2_r;
  logic [7:0]      word_mem [MAX_WORD_LEN];
  logic [7:0]      rd_data_r;

  logic            can_load;
  logic [LENW-1:0] len_eff;
  logic            has_eff;
  logic            wr_en;
  logic            word_trunc;
  logic            keep;

  logic            out_load;
  logic            o_kind, o_end, o_trunc, o_last;
  logic [7:0]      o_char;

  logic            out_valid_r;
  logic            out_kind_r, out_end_r, out_trunc_r, out_last_r;
  logic [7:0]      out_char_r;

  // output register can take a new result
  assign can_load = !out_valid_r || !out_stall;

  // word and sentence state as seen by a new command
  always_comb begin
    len_eff    = inside_r ? len_r : '0;
    has_eff    = inside_r && has_r;
    word_trunc = (len_eff == LEN_SAT);
    keep       = (len_eff != '0) && (CW'(len_eff) > min_len_r) && first_letter_r &&
                 !(!word_trunc && len_eff == LENW'(1) && c0_r == wst_pkg::CH_LOW_A) &&
                 !(!word_trunc && len_eff == LENW'(3) && c0_r == wst_pkg::CH_LOW_T &&
                   c1_r == wst_pkg::CH_LOW_H && c2_r == wst_pkg::CH_LOW_E);
  end

  // command execution and emission sequencing
  always_comb begin
    state_nxt    = state_r;
    len_nxt      = len_r;
    inside_nxt   = inside_r;
    has_nxt      = has_r;
    idx_nxt      = idx_r;
    last_idx_nxt = last_idx_r;
    trunc_nxt    = trunc_r;
    mark_nxt     = mark_r;
    cmd_pop      = 1'b0;
    wr_en        = 1'b0;
    out_load     = 1'b0;
    o_kind       = wst_pkg::KIND_CHAR;
    o_char       = '0;
    o_end        = 1'b0;
    o_trunc      = 1'b0;
    o_last       = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        idx_nxt = '0;
        if (cmd_valid && can_load) begin
          cmd_pop = 1'b1;
          unique case (cmd.op)
            wst_pkg::CMD_CHAR: begin
              wr_en      = (len_eff < LEN_MAX);
              len_nxt    = (len_eff == LEN_SAT) ? len_eff : len_eff + 1'b1;
              inside_nxt = 1'b1;
              has_nxt    = has_eff;
            end
            wst_pkg::CMD_SEP: begin
              len_nxt    = '0;
              inside_nxt = !cmd.sent_end;
              if (keep) begin
                state_nxt    = S_EMIT;
                last_idx_nxt = word_trunc ? IDXW'(MAX_WORD_LEN - 1)
                                          : IDXW'(len_eff - 1'b1);
                trunc_nxt    = word_trunc;
                mark_nxt     = cmd.sent_end;
                has_nxt      = !cmd.sent_end;
              end else begin
                if (cmd.sent_end && has_eff) begin
                  out_load = 1'b1;
                  o_kind   = wst_pkg::KIND_MARKER;
                  o_last   = 1'b1;
                end
                has_nxt = has_eff && !cmd.sent_end;
              end
            end
            wst_pkg::CMD_EOI: begin
              if (has_eff) begin
                out_load = 1'b1;
                o_kind   = wst_pkg::KIND_MARKER;
                o_last   = 1'b1;
              end
              len_nxt    = '0;
              has_nxt    = 1'b0;
              inside_nxt = 1'b0;
            end
            default: begin
              cmd_pop = 1'b1;
            end
          endcase
        end
      end
      S_EMIT: begin
        if (can_load) begin
          out_load = 1'b1;
          o_kind   = wst_pkg::KIND_CHAR;
          o_char   = rd_data_r;
          o_end    = (idx_r == last_idx_r);
          o_trunc  = trunc_r;
          o_last   = (idx_r == last_idx_r) && !mark_r;
          idx_nxt  = idx_r + 1'b1;
          if (idx_r == last_idx_r) begin
            state_nxt = mark_r ? S_MARK : S_IDLE;
          end
        end
      end
      S_MARK: begin
        if (can_load) begin
          out_load  = 1'b1;
          o_kind    = wst_pkg::KIND_MARKER;
          o_last    = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      min_len_r   <= CW'(1);
      len_r       <= '0;
      inside_r    <= 1'b0;
      has_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      len_r    <= len_nxt;
      inside_r <= inside_nxt;
      has_r    <= has_nxt;
      if (cfg_valid) begin
        min_len_r <= cfg_data;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // emission bookkeeping and first characters for the keep test
  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    last_idx_r <= last_idx_nxt;
    trunc_r    <= trunc_nxt;
    mark_r     <= mark_nxt;
    if (wr_en && len_eff == LENW'(0)) begin
      first_letter_r <= cmd.is_letter;
      c0_r           <= cmd.ch;
    end
    if (wr_en && len_eff == LENW'(1)) begin
      c1_r <= cmd.ch;
    end
    if (wr_en && len_eff == LENW'(2)) begin
      c2_r <= cmd.ch;
    end
  end

  // word store, one write port and one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      word_mem[len_eff[IDXW-1:0]] <= cmd.ch;
    end
    rd_data_r <= word_mem[idx_nxt];
  end

  // output payload register
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_kind_r  <= o_kind;
      out_char_r  <= o_char;
      out_end_r   <= o_end;
      out_trunc_r <= o_trunc;
      out_last_r  <= o_last;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_kind      = out_kind_r;
  assign out_word_char = out_char_r;
  assign out_word_end  = out_end_r;
  assign out_truncated = out_trunc_r;
  assign out_last      = out_last_r;

endmodule
`default_nettype wire

// ===== rtl/core/word_sentence_tokenizer.sv =====
// word and sentence tokenizer: top level joining front end and back end
//
// Usage:
//   in_* channel takes one item per transfer: in_operation 0 carries a text
//   byte in in_text_byte, in_operation 1 marks end of input. out_* channel
//   gives result items: word characters (kind 0) and sentence markers
//   (kind 1), with out_last set on the final result of each input item.
//   cfg_* writes min_word_len; cfg_ready is always high, write only while idle.
// Flow:
//   a front queue of four commands absorbs input; the back end handles one
//   command a cycle unless the output stalls or a word is being emitted.
//   A kept word's characters are emitted after its separator is taken, then
//   a marker if it ends the sentence. Results are registered at the output.
// Reset:
//   synchronous, active low; clears the queue, word and sentence state and
//   sets min_word_len to 1. The word store needs no clearing.
// Stall:
//   out_stall holds the output register; the back end waits and the queue
//   fills, then in_stall rises until room frees up.
`timescale 1ns / 1ps
`default_nettype none
module word_sentence_tokenizer #(
  parameter int MAX_WORD_LEN = 32
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic                      in_operation,
  input  wire logic [7:0]                in_text_byte,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic                           out_kind,
  output logic [7:0]                     out_word_char,
  output logic                           out_word_end,
  output logic                           out_truncated,
  output logic                           out_last,
  input  wire logic                      cfg_valid,
  output logic                           cfg_ready,
  input  wire logic [wst_pkg::CFG_W-1:0] cfg_data
);

  wst_pkg::tok_cmd_t cmd;
  logic              cmd_valid;
  logic              cmd_pop;

  assign cfg_ready = 1'b1;

  // classifier and command queue
  wst_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_operation (in_operation),
    .in_text_byte (in_text_byte),
    .cmd_valid    (cmd_valid),
    .cmd          (cmd),
    .cmd_pop      (cmd_pop)
  );

  // word buffer and result emission
  wst_back #(
    .MAX_WORD_LEN (MAX_WORD_LEN)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_valid     (cfg_valid),
    .cfg_data      (cfg_data),
    .cmd_valid     (cmd_valid),
    .cmd           (cmd),
    .cmd_pop       (cmd_pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_kind      (out_kind),
    .out_word_char (out_word_char),
    .out_word_end  (out_word_end),
    .out_truncated (out_truncated),
    .out_last      (out_last)
  );

endmodule
`default_nettype wire

// ===== tb/word_sentence_tokenizer_checker.sv =====
// checker for the word and sentence tokenizer: predicts tokens and compares results
`timescale 1ns / 1ps
module word_sentence_tokenizer_checker #(
  parameter int MAX_WORD_LEN = 32
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic                      in_stall,
  input  logic                      in_operation,
  input  logic [7:0]                in_text_byte,
  input  logic                      out_valid,
  input  logic                      out_stall,
  input  logic                      out_kind,
  input  logic [7:0]                out_word_char,
  input  logic                      out_word_end,
  input  logic                      out_truncated,
  input  logic                      out_last,
  input  logic                      cfg_valid,
  input  logic                      cfg_ready,
  input  logic [wst_pkg::CFG_W-1:0] cfg_data,
  output int                        fail_count,
  output int                        pending,
  output int                        checked
);

  localparam int CW = wst_pkg::CFG_W;

  typedef enum logic [1:0] {
    MODE_BEFORE_TEXT   = 2'd0,
    MODE_IN_SENTENCE   = 2'd1,
    MODE_SENTENCE_DONE = 2'd2
  } parse_mode_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] ch;
    logic       wend;
    logic       trunc;
    logic       last;
  } token_t;

  // predicted tokenizer state
  logic [CW-1:0]    min_len;
  logic [7:0]       word_buf [MAX_WORD_LEN];
  int               word_len;
  parse_mode_t      mode;
  logic             sentence_kept;

  token_t token_q [$];
  token_t want;

  function automatic logic is_alpha(logic [7:0] c);
    return (c >= wst_pkg::CH_UP_A && c <= wst_pkg::CH_UP_Z) ||
           (c >= wst_pkg::CH_LOW_A && c <= wst_pkg::CH_LOW_Z);
  endfunction

  function automatic logic is_word_byte(logic [7:0] c);
    return is_alpha(c) || (c >= wst_pkg::CH_ZERO && c <= wst_pkg::CH_NINE) ||
           c == wst_pkg::CH_DASH || c == wst_pkg::CH_AMP;
  endfunction

  task automatic report_mismatch(string msg);
    $display("[%0t] MISMATCH %s", $time, msg);
    fail_count++;
  endtask

  task automatic check_field(string name, logic [7:0] got, logic [7:0] exp_val);
    if (got !== exp_val)
      report_mismatch($sformatf("result %0d: %s is %0h, predicted %0h",
                                checked, name, got, exp_val));
  endtask

  task automatic push_token(logic kind, logic [7:0] ch, logic wend, logic trunc);
    token_t t;
    t = '{kind: kind, ch: ch, wend: wend, trunc: trunc, last: 1'b0};
    token_q.insert(token_q.size(), t);
  endtask

  // decide whether the open word survives the filters and emit it
  task automatic close_word();
    int   stored;
    logic trunc;
    logic keep;
    if (word_len == 0) return;
    trunc  = word_len > MAX_WORD_LEN;
    stored = trunc ? MAX_WORD_LEN : word_len;
    keep   = 1'b1;
    if (word_len <= int'(min_len))
      keep = 1'b0;
    else if (!is_alpha(word_buf[0]))
      keep = 1'b0;
    else if (!trunc && word_len == 1 && word_buf[0] == wst_pkg::CH_LOW_A)
      keep = 1'b0;
    else if (!trunc && word_len == 3 && word_buf[0] == wst_pkg::CH_LOW_T &&
             word_buf[1] == wst_pkg::CH_LOW_H && word_buf[2] == wst_pkg::CH_LOW_E)
      keep = 1'b0;
    if (keep) begin
      for (int i = 0; i < stored; i++)
        push_token(wst_pkg::KIND_CHAR, word_buf[i], i + 1 == stored, trunc);
      sentence_kept = 1'b1;
    end
    word_len = 0;
  endtask

  // expected tokens for one accepted input transfer
  task automatic tokenize_item(logic op, logic [7:0] b);
    int         first;
    logic       stop;
    logic [7:0] ch;
    first = token_q.size();
    if (op == wst_pkg::OP_EOI) begin
      if (mode == MODE_IN_SENTENCE && sentence_kept)
        push_token(wst_pkg::KIND_MARKER, 8'h00, 1'b0, 1'b0);
      word_len      = 0;
      sentence_kept = 1'b0;
      mode          = MODE_BEFORE_TEXT;
    end else begin
      stop = b == wst_pkg::CH_PERIOD || b == wst_pkg::CH_QUEST || b == wst_pkg::CH_EXCL;
      if (mode != MODE_IN_SENTENCE) begin
        word_len      = 0;
        sentence_kept = 1'b0;
        mode          = MODE_IN_SENTENCE;
      end
      if (stop || !is_word_byte(b)) begin
        close_word();
        if (stop) begin
          mode = MODE_SENTENCE_DONE;
          if (sentence_kept)
            push_token(wst_pkg::KIND_MARKER, 8'h00, 1'b0, 1'b0);
          sentence_kept = 1'b0;
        end
      end else begin
        ch = (b >= wst_pkg::CH_UP_A && b <= wst_pkg::CH_UP_Z) ? (b | wst_pkg::CASE_BIT) : b;
        if (word_len < MAX_WORD_LEN) word_buf[word_len] = ch;
        if (word_len < MAX_WORD_LEN + 1) word_len++;
      end
    end
    if (token_q.size() > first)
      token_q[token_q.size() - 1].last = 1'b1;
  endtask

  initial begin
    fail_count = 0;
    pending    = 0;
    checked    = 0;
  end

  // watch config, input and result transfers
  always @(posedge clk) begin
    if (!rst_n) begin
      min_len       = CW'(1);
      word_len      = 0;
      mode          = MODE_BEFORE_TEXT;
      sentence_kept = 1'b0;
      token_q.delete();
    end else begin
      if (cfg_valid && cfg_ready)
        min_len = cfg_data;
      if (in_valid && !in_stall)
        tokenize_item(in_operation, in_text_byte);
      if (out_valid && !out_stall) begin
        if (token_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result: kind %0d char %0h last %0d",
                                    out_kind, out_word_char, out_last));
        end else begin
          want = token_q.pop_front();
          check_field("kind", 8'(out_kind), 8'(want.kind));
          check_field("word_char", out_word_char, want.ch);
          check_field("word_end", 8'(out_word_end), 8'(want.wend));
          check_field("truncated", 8'(out_truncated), 8'(want.trunc));
          check_field("last", 8'(out_last), 8'(want.last));
        end
        checked++;
      end
    end
    pending = token_q.size();
  end

endmodule

// ===== tb/tb_word_sentence_tokenizer.sv =====
// testbench top for the word and sentence tokenizer: stimulus, idling and verdict
`timescale 1ns / 1ps
module tb_word_sentence_tokenizer;

  localparam int WORD_MAX  = 32;
  localparam int RUN_LIMIT = 1000000;

  logic                      clk;
  logic                      rst_n;
  logic                      in_valid;
  logic                      in_stall;
  logic                      in_operation;
  logic [7:0]                in_text_byte;
  logic                      out_valid;
  logic                      out_stall;
  logic                      out_kind;
  logic [7:0]                out_word_char;
  logic                      out_word_end;
  logic                      out_truncated;
  logic                      out_last;
  logic                      cfg_valid;
  logic                      cfg_ready;
  logic [wst_pkg::CFG_W-1:0] cfg_data;

  int fail_count;
  int pending;
  int checked;
  int items_sent;
  int settings_used;
  int cycle_count;
  bit calm;

  word_sentence_tokenizer #(.MAX_WORD_LEN(WORD_MAX)) DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_operation  (in_operation),
    .in_text_byte  (in_text_byte),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_kind      (out_kind),
    .out_word_char (out_word_char),
    .out_word_end  (out_word_end),
    .out_truncated (out_truncated),
    .out_last      (out_last),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  word_sentence_tokenizer_checker #(.MAX_WORD_LEN(WORD_MAX)) u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_operation  (in_operation),
    .in_text_byte  (in_text_byte),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_kind      (out_kind),
    .out_word_char (out_word_char),
    .out_word_end  (out_word_end),
    .out_truncated (out_truncated),
    .out_last      (out_last),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .fail_count    (fail_count),
    .pending       (pending),
    .checked       (checked)
  );

  // clock
  initial clk = 1'b0;
  always #1 clk = ~clk;

  // run limit
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= RUN_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still predicted", cycle_count, pending);
      $display("Some tests failed");
      $finish;
    end
  end

  // result side: stall a random number of cycles before each transfer
  initial begin
    int hold;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      hold = calm ? 0 : $urandom_range(0, 13);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
    end
  end

  // one input transfer after a random gap; valid stays up for a back-to-back item
  task automatic send_item(logic op, logic [7:0] b);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_operation <= op;
    in_text_byte <= b;
    do @(posedge clk); while (!(in_valid && !in_stall));
    @(negedge clk);
    items_sent++;
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++)
      send_item(wst_pkg::OP_TEXT, s[i]);
  endtask

  // lead 0: any word byte, 1: letter, 2: digit, dash or ampersand
  function automatic logic [7:0] random_word_char(int lead);
    int r;
    r = (lead == 1) ? $urandom_range(0, 7) :
        (lead == 2) ? $urandom_range(8, 9) : $urandom_range(0, 9);
    if (r < 5) return wst_pkg::CH_LOW_A + 8'($urandom_range(0, 25));
    if (r < 8) return wst_pkg::CH_UP_A + 8'($urandom_range(0, 25));
    if (r == 8) return wst_pkg::CH_ZERO + 8'($urandom_range(0, 9));
    return $urandom_range(0, 1) ? wst_pkg::CH_DASH : wst_pkg::CH_AMP;
  endfunction

  task automatic send_separator();
    logic [7:0] b;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: b = 8'h20;
      4:          b = 8'h2c;
      5:          b = 8'($urandom_range(128, 255));
      6:          b = wst_pkg::CH_PERIOD;
      7:          b = wst_pkg::CH_QUEST;
      8:          b = wst_pkg::CH_EXCL;
      default:    b = 8'h0a;
    endcase
    send_item(wst_pkg::OP_TEXT, b);
  endtask

  // mostly words and separators, with noise bytes and end-of-input marks
  task automatic send_random_text(int budget, int long_pct);
    int first;
    int r;
    int len;
    first = items_sent;
    while (items_sent - first < budget) begin
      if ($urandom_range(0, 11) == 0) calm = ~calm;
      r = $urandom_range(0, 99);
      if (r < 3) begin
        send_item(wst_pkg::OP_EOI, 8'($urandom_range(0, 255)));
      end else if (r < 13) begin
        send_item(wst_pkg::OP_TEXT, 8'($urandom_range(0, 255)));
      end else begin
        if (r < 21) begin
          case ($urandom_range(0, 3))
            0:       send_text("a");
            1:       send_text("the");
            2:       send_text("The");
            default: send_text("A");
          endcase
        end else begin
          len = ($urandom_range(0, 99) < long_pct) ? $urandom_range(30, 40)
                                                   : $urandom_range(1, 7);
          send_item(wst_pkg::OP_TEXT,
                    random_word_char(($urandom_range(0, 9) == 0) ? 2 : 1));
          for (int i = 1; i < len; i++)
            send_item(wst_pkg::OP_TEXT, random_word_char(0));
        end
        send_separator();
      end
    end
  endtask

  // let every predicted result drain, plus the block's internal queue
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic set_min_word_len(logic [wst_pkg::CFG_W-1:0] v);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    @(negedge clk);
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  // stimulus
  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_operation  = wst_pkg::OP_TEXT;
    in_text_byte  = 8'h00;
    cfg_valid     = 1'b0;
    cfg_data      = '0;
    items_sent    = 0;
    settings_used = 1;
    calm          = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed text at the reset word length: word bytes, high-byte separator,
    // empty word, digit lead, "the", marker, bare sentence end, discarded word
    send_text("Za-&9");
    send_item(wst_pkg::OP_TEXT, 8'hff);
    send_text(" 9x,The !.Qz mn");
    send_item(wst_pkg::OP_EOI, 8'h00);
    send_item(wst_pkg::OP_EOI, 8'hff);
    send_random_text(12, 5);

    // every word kept except the stop words and non-letter leads
    set_min_word_len(6'd0);
    send_random_text(12, 5);

    // only truncated words are long enough
    set_min_word_len(6'd32);
    send_random_text(20, 30);

    calm = 1'b1;
    set_min_word_len(6'($urandom_range(2, 6)));
    send_random_text(10, 5);

    set_min_word_len(6'd1);
    send_random_text(8, 5);

    wait_idle();
    $display("sent %0d input items under %0d word length settings", items_sent, settings_used);
    $display("compared %0d tokens, %0d mismatches", checked, fail_count);
    if (fail_count == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
